// ===== sv/civil_date_to_epoch_seconds_unit_defines.svh =====
// Assertion macros shared by the conversion pipeline.
// Each macro expects clk and rst_n in the scope where it is used.
`ifndef CIVIL_DATE_TO_EPOCH_SECONDS_UNIT_DEFINES_SVH
`define CIVIL_DATE_TO_EPOCH_SECONDS_UNIT_DEFINES_SVH

`ifndef SYNTH

// Check that the consequent holds in the same cycle as the antecedent
`define CDES_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("cdes assertion failed");

// Check that the consequent holds in the cycle after the antecedent
`define CDES_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("cdes assertion failed");

`else

`define CDES_ASSERT_IMP(lbl, ante, cons)
`define CDES_ASSERT_NEXT(lbl, ante, cons)

`endif

`endif

// ===== sv/cdes_pkg.sv =====
`default_nettype none

package cdes_pkg;

  // Field widths
  localparam int YEAR_W   = 14;
  localparam int MONTH_W  = 4;
  localparam int DAY_W    = 5;
  localparam int HOUR_W   = 5;
  localparam int MIN_W    = 6;
  localparam int SEC_W    = 6;
  localparam int ZONE_W   = 17;
  localparam int EPOCH_W  = 39;
  localparam int DOY_W    = 9;
  localparam int WD_W     = 3;

  // Internal widths
  localparam int YDAYS_W  = 22;  // days from year 0 to Jan 1 of a valid year
  localparam int TOD_W    = 17;  // seconds in the day
  localparam int DAYS_W   = 24;  // signed day number relative to the epoch
  localparam int TADJ_W   = 19;  // signed time of day minus zone offset
  localparam int WDX_W    = 23;  // biased day number for the weekday
  localparam int Q7_W     = 21;  // quotient of the biased day number by seven

  // Calendar limits and named months
  localparam logic [YEAR_W-1:0]  MAX_YEAR   = 14'd9999;
  localparam logic [MONTH_W-1:0] MONTH_JAN  = 4'd1;
  localparam logic [MONTH_W-1:0] MONTH_FEB  = 4'd2;
  localparam logic [MONTH_W-1:0] MONTH_DEC  = 4'd12;
  localparam logic [HOUR_W-1:0]  HOURS_IN_DAY  = 5'd24;
  localparam logic [MIN_W-1:0]   MINS_PER_HOUR = 6'd60;
  localparam logic [SEC_W-1:0]   SECS_PER_MIN  = 6'd60;

  // Constant-divisor reciprocals: floor(x/100) = (x*5243) >> 19 for x < 43690
  localparam logic [12:0] DIV100_MUL   = 13'd5243;
  localparam int          DIV100_SHIFT = 19;
  // floor(x/7) = (x*38347923) >> 28 for x < 7.6 million
  localparam logic [25:0] DIV7_MUL     = 26'd38347923;
  localparam int          DIV7_SHIFT   = 28;

  localparam logic [8:0]  DAYS_PER_YEAR = 9'd365;
  localparam logic [11:0] SECS_PER_HOUR = 12'd3600;
  localparam logic [16:0] SECS_PER_DAY  = 17'd86400;

  // Days from 0000-01-01 to 1970-01-01, plus one for the 1-based day of year
  localparam logic [DAYS_W-1:0] EPOCH_DAY_BIAS = 24'd719529;
  // 4 (Thursday) plus 7*200000 less the same bias keeps the weekday operand positive
  localparam logic [WDX_W-1:0]  WD_DAY_BIAS    = 23'd680475;

  // One input request
  typedef struct packed {
    logic [YEAR_W-1:0]        year_value;
    logic [MONTH_W-1:0]       month_value;
    logic [DAY_W-1:0]         day_value;
    logic [HOUR_W-1:0]        hour_value;
    logic [MIN_W-1:0]         minute_value;
    logic [SEC_W-1:0]         second_value;
    logic signed [ZONE_W-1:0] zone_offset;
  } cdes_item_t;

  // Date stage result handed to the time stage
  typedef struct packed {
    logic                     ok;
    logic [DOY_W-1:0]         doy;
    logic [YDAYS_W-1:0]       ydays;
    logic [TOD_W-1:0]         tod;
    logic signed [ZONE_W-1:0] zone;
  } cdes_date_t;

  // One result request
  typedef struct packed {
    logic signed [EPOCH_W-1:0] epoch_seconds;
    logic [DOY_W-1:0]          day_of_year;
    logic [WD_W-1:0]           weekday;
    logic                      date_valid;
  } cdes_result_t;

  // Days before the first of the month, common year
  function automatic logic [DOY_W-1:0] month_start_f(input logic [MONTH_W-1:0] m);
    logic [DOY_W-1:0] r;
    case (m)
      4'd1:    r = 9'd0;
      4'd2:    r = 9'd31;
      4'd3:    r = 9'd59;
      4'd4:    r = 9'd90;
      4'd5:    r = 9'd120;
      4'd6:    r = 9'd151;
      4'd7:    r = 9'd181;
      4'd8:    r = 9'd212;
      4'd9:    r = 9'd243;
      4'd10:   r = 9'd273;
      4'd11:   r = 9'd304;
      4'd12:   r = 9'd334;
      default: r = 9'd0;
    endcase
    return r;
  endfunction

  // Month length, common year
  function automatic logic [DAY_W-1:0] month_len_f(input logic [MONTH_W-1:0] m);
    logic [DAY_W-1:0] r;
    case (m)
      4'd1:    r = 5'd31;
      4'd2:    r = 5'd28;
      4'd3:    r = 5'd31;
      4'd4:    r = 5'd30;
      4'd5:    r = 5'd31;
      4'd6:    r = 5'd30;
      4'd7:    r = 5'd31;
      4'd8:    r = 5'd31;
      4'd9:    r = 5'd30;
      4'd10:   r = 5'd31;
      4'd11:   r = 5'd30;
      4'd12:   r = 5'd31;
      default: r = 5'd0;
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

// ===== sv/cdes_if.sv =====
`default_nettype none

// Input request channel
interface cdes_req_if import cdes_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic [YEAR_W-1:0]        year_value;
  logic [MONTH_W-1:0]       month_value;
  logic [DAY_W-1:0]         day_value;
  logic [HOUR_W-1:0]        hour_value;
  logic [MIN_W-1:0]         minute_value;
  logic [SEC_W-1:0]         second_value;
  logic signed [ZONE_W-1:0] zone_offset;

  modport source (
    output valid, year_value, month_value, day_value, hour_value,
           minute_value, second_value, zone_offset,
    input  ready
  );
  modport sink (
    input  valid, year_value, month_value, day_value, hour_value,
           minute_value, second_value, zone_offset,
    output ready
  );
endinterface

// Result request channel
interface cdes_rsp_if import cdes_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic signed [EPOCH_W-1:0] epoch_seconds;
  logic [DOY_W-1:0]          day_of_year;
  logic [WD_W-1:0]           weekday;
  logic                      date_valid;

  modport source (
    output valid, epoch_seconds, day_of_year, weekday, date_valid,
    input  ready
  );
  modport sink (
    input  valid, epoch_seconds, day_of_year, weekday, date_valid,
    output ready
  );
endinterface

`default_nettype wire

// ===== sv/cdes_date_front.sv =====
`default_nettype none
`include "civil_date_to_epoch_seconds_unit_defines.svh"

// Two stages: field checks and year quotients, then leap rule, month length,
// day of year, days before the year and time of day.
module cdes_date_front import cdes_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire cdes_item_t in_item,
  output logic            out_valid,
  input  wire logic       out_ready,
  output cdes_date_t      out_data
);

  // Stage enables
  logic ready1;
  logic ready2;

  // Stage 1 registers
  logic                     v1_r;
  logic [YEAR_W-1:0]        year_r;
  logic [MONTH_W-1:0]       month_r;
  logic [DAY_W-1:0]         day_r;
  logic [HOUR_W-1:0]        hour_r;
  logic [MIN_W-1:0]         minute_r;
  logic [SEC_W-1:0]         second_r;
  logic signed [ZONE_W-1:0] zone_r;
  logic                     range_ok_r;
  logic [7:0]               q100_r;
  logic [7:0]               qa_r;
  logic [5:0]               qb_r;

  logic                     range_ok_nxt;
  logic [7:0]               q100_nxt;
  logic [7:0]               qa_nxt;
  logic [5:0]               qb_nxt;
  logic [YEAR_W:0]          year_p99;
  logic [YEAR_W:0]          year_p399;
  logic [26:0]              prod100;
  logic [27:0]              prod99;
  logic [25:0]              prod399;

  // Stage 2 registers
  logic                     v2_r;
  cdes_date_t               s2_r;
  cdes_date_t               s2_nxt;

  logic [YEAR_W:0]          hund;
  logic [YEAR_W:0]          year_p3;
  logic                     y_div100;
  logic                     leap;
  logic [DAY_W-1:0]         mlen;
  logic                     day_ok;
  logic [12:0]              leap_cnt;
  logic [YDAYS_W:0]         ydays_full;

  assign ready2   = !v2_r || out_ready;
  assign ready1   = !v1_r || ready2;
  assign in_ready = ready1;

  // Range checks that need no leap rule, and quotients by 100 and 400
  always_comb begin
    range_ok_nxt = (in_item.year_value <= MAX_YEAR)
                && (in_item.hour_value < HOURS_IN_DAY)
                && (in_item.minute_value < MINS_PER_HOUR)
                && (in_item.second_value < SECS_PER_MIN)
                && (in_item.month_value >= MONTH_JAN)
                && (in_item.month_value <= MONTH_DEC);
    year_p99  = {1'b0, in_item.year_value} + 15'd99;
    year_p399 = {1'b0, in_item.year_value} + 15'd399;
    prod100   = 27'(in_item.year_value) * 27'(DIV100_MUL);
    prod99    = 28'(year_p99) * 28'(DIV100_MUL);
    prod399   = 26'(year_p399[YEAR_W:2]) * 26'(DIV100_MUL);
    q100_nxt  = prod100[DIV100_SHIFT+7:DIV100_SHIFT];
    qa_nxt    = prod99[DIV100_SHIFT+7:DIV100_SHIFT];
    qb_nxt    = prod399[DIV100_SHIFT+5:DIV100_SHIFT];
  end

  // Advance stage 1
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else if (ready1) begin
      v1_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (ready1) begin
      year_r     <= in_item.year_value;
      month_r    <= in_item.month_value;
      day_r      <= in_item.day_value;
      hour_r     <= in_item.hour_value;
      minute_r   <= in_item.minute_value;
      second_r   <= in_item.second_value;
      zone_r     <= in_item.zone_offset;
      range_ok_r <= range_ok_nxt;
      q100_r     <= q100_nxt;
      qa_r       <= qa_nxt;
      qb_r       <= qb_nxt;
    end
  end

  // Leap rule, day check, day of year, days before the year, time of day
  always_comb begin
    hund     = 15'(q100_r) * 15'd100;
    y_div100 = (hund == {1'b0, year_r});
    leap     = (year_r[1:0] == 2'b00) && (!y_div100 || (q100_r[1:0] == 2'b00));
    mlen     = month_len_f(month_r) + 5'(leap && (month_r == MONTH_FEB));
    day_ok   = (day_r != '0) && (day_r <= mlen);
    year_p3  = {1'b0, year_r} + 15'd3;
    // leap years in [0, year): year/4 - year/100 + year/400, rounded up
    leap_cnt   = 13'(year_p3[YEAR_W:2]) - 13'(qa_r) + 13'(qb_r);
    ydays_full = 23'(year_r) * 23'(DAYS_PER_YEAR) + 23'(leap_cnt);

    s2_nxt.ok    = range_ok_r && day_ok;
    s2_nxt.doy   = month_start_f(month_r) + 9'(day_r)
                 + 9'(leap && (month_r > MONTH_FEB));
    s2_nxt.ydays = ydays_full[YDAYS_W-1:0];
    s2_nxt.tod   = 17'(hour_r) * 17'(SECS_PER_HOUR)
                 + 17'(minute_r) * 17'(SECS_PER_MIN)
                 + 17'(second_r);
    s2_nxt.zone  = zone_r;
  end

  // Advance stage 2
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else if (ready2) begin
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (ready2) begin
      s2_r <= s2_nxt;
    end
  end

  assign out_valid = v2_r;
  assign out_data  = s2_r;

  `CDES_ASSERT_IMP(a_front_doy_range, v2_r && s2_r.ok, (s2_r.doy >= 9'd1) && (s2_r.doy <= 9'd366))
  `CDES_ASSERT_NEXT(a_front_stall_hold, v2_r && !out_ready, v2_r)
  `CDES_ASSERT_NEXT(a_front_advance, v1_r && ready2, v2_r)

endmodule

`default_nettype wire

// ===== sv/cdes_time_back.sv =====
`default_nettype none
`include "civil_date_to_epoch_seconds_unit_defines.svh"

// Three stages: epoch day number, day and weekday products, final sums.
module cdes_time_back import cdes_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire cdes_date_t in_data,
  output logic            out_valid,
  input  wire logic       out_ready,
  output cdes_result_t    out_data
);

  logic ready3;
  logic ready4;
  logic ready5;

  // Stage 3
  logic                     v3_r;
  logic                     ok3_r;
  logic [DOY_W-1:0]         doy3_r;
  logic signed [DAYS_W-1:0] days_r;
  logic [WDX_W-1:0]         wdx3_r;
  logic signed [TADJ_W-1:0] tadj3_r;
  logic signed [DAYS_W-1:0] days_nxt;
  logic [WDX_W-1:0]         wdx_nxt;
  logic signed [TADJ_W-1:0] tadj_nxt;

  // Stage 4
  logic                      v4_r;
  logic                      ok4_r;
  logic [DOY_W-1:0]          doy4_r;
  logic [WDX_W-1:0]          wdx4_r;
  logic signed [TADJ_W-1:0]  tadj4_r;
  logic signed [EPOCH_W-1:0] dsec_r;
  logic [Q7_W-1:0]           q7_r;
  logic signed [EPOCH_W-1:0] dsec_nxt;
  logic [48:0]               prod7;
  logic [Q7_W-1:0]           q7_nxt;

  // Stage 5
  logic                      v5_r;
  cdes_result_t              res_r;
  cdes_result_t              res_nxt;
  logic signed [EPOCH_W-1:0] secs;
  logic [WDX_W-1:0]          wd_full;

  assign ready5   = !v5_r || out_ready;
  assign ready4   = !v4_r || ready5;
  assign ready3   = !v3_r || ready4;
  assign in_ready = ready3;

  // Day number relative to the epoch, biased weekday operand, shifted time
  always_comb begin
    days_nxt = $signed({2'b00, in_data.ydays}) + $signed({15'd0, in_data.doy})
             - $signed(EPOCH_DAY_BIAS);
    wdx_nxt  = 23'(in_data.ydays) + 23'(in_data.doy) + WD_DAY_BIAS;
    tadj_nxt = $signed({2'b00, in_data.tod})
             - $signed({{(TADJ_W-ZONE_W){in_data.zone[ZONE_W-1]}}, in_data.zone});
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v3_r <= 1'b0;
    end else if (ready3) begin
      v3_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (ready3) begin
      ok3_r   <= in_data.ok;
      doy3_r  <= in_data.doy;
      days_r  <= days_nxt;
      wdx3_r  <= wdx_nxt;
      tadj3_r <= tadj_nxt;
    end
  end

  // Seconds of whole days, and the quotient by seven for the weekday
  always_comb begin
    dsec_nxt = $signed({{(EPOCH_W-DAYS_W){days_r[DAYS_W-1]}}, days_r})
             * $signed(39'(SECS_PER_DAY));
    prod7    = 49'(wdx3_r) * 49'(DIV7_MUL);
    q7_nxt   = prod7[DIV7_SHIFT+Q7_W-1:DIV7_SHIFT];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v4_r <= 1'b0;
    end else if (ready4) begin
      v4_r <= v3_r;
    end
  end

  always_ff @(posedge clk) begin
    if (ready4) begin
      ok4_r   <= ok3_r;
      doy4_r  <= doy3_r;
      wdx4_r  <= wdx3_r;
      tadj4_r <= tadj3_r;
      dsec_r  <= dsec_nxt;
      q7_r    <= q7_nxt;
    end
  end

  // Final sum and remainder; drop everything to zero on an invalid date
  always_comb begin
    secs    = dsec_r + $signed({{(EPOCH_W-TADJ_W){tadj4_r[TADJ_W-1]}}, tadj4_r});
    wd_full = wdx4_r - 23'(q7_r) * 23'd7;
    if (ok4_r) begin
      res_nxt.epoch_seconds = secs;
      res_nxt.day_of_year   = doy4_r;
      res_nxt.weekday       = wd_full[WD_W-1:0];
      res_nxt.date_valid    = 1'b1;
    end else begin
      res_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v5_r <= 1'b0;
    end else if (ready5) begin
      v5_r <= v4_r;
    end
  end

  always_ff @(posedge clk) begin
    if (ready5) begin
      res_r <= res_nxt;
    end
  end

  assign out_valid = v5_r;
  assign out_data  = res_r;

  `CDES_ASSERT_IMP(a_back_invalid_zero, v5_r && !res_r.date_valid, (res_r.epoch_seconds == '0) && (res_r.day_of_year == '0) && (res_r.weekday == '0))
  `CDES_ASSERT_IMP(a_back_weekday_range, v5_r && res_r.date_valid, res_r.weekday <= 3'd6)
  `CDES_ASSERT_NEXT(a_back_advance, v3_r && ready4, v4_r)

endmodule

`default_nettype wire

// ===== sv/civil_date_to_epoch_seconds_unit.sv =====
// Civil date and time to Unix epoch seconds.
// in_ch carries one request per date: year, month, day, hour, minute,
// second and a zone offset in seconds that is subtracted from local time.
// out_ch returns one result per request, in order: epoch seconds (39-bit
// two's complement), 1-based day of year, local weekday (0 is Sunday) and
// date_valid. A date with any field out of range returns all zeros.
// Both channels transfer when valid and ready are high at a rising edge.
// Five register stages: field checks, date fields, epoch day number, day and
// weekday products, final sums; each request passes them in that order.
// Throughput is one request per cycle while out_ch.ready is high; each
// stage holds one request and takes a new one whenever it is empty or
// the stage after it advances. When the receiver holds ready low the
// result stays put and the stages behind it keep filling until the
// pipeline is full, then in_ch.ready drops; nothing is lost or repeated.
// Synchronous active-low reset clears all valid bits; the block can take a
// request as soon as reset is released.
`default_nettype none

module civil_date_to_epoch_seconds_unit import cdes_pkg::*; (
  input  wire logic  clk,
  input  wire logic  rst_n,
  cdes_req_if.sink   in_ch,
  cdes_rsp_if.source out_ch
);

  cdes_item_t   in_item;
  logic         mid_valid;
  logic         mid_ready;
  cdes_date_t   mid_data;
  cdes_result_t res;

  // Gather the request fields
  always_comb begin
    in_item.year_value   = in_ch.year_value;
    in_item.month_value  = in_ch.month_value;
    in_item.day_value    = in_ch.day_value;
    in_item.hour_value   = in_ch.hour_value;
    in_item.minute_value = in_ch.minute_value;
    in_item.second_value = in_ch.second_value;
    in_item.zone_offset  = in_ch.zone_offset;
  end

  cdes_date_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .in_item   (in_item),
    .out_valid (mid_valid),
    .out_ready (mid_ready),
    .out_data  (mid_data)
  );

  cdes_time_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (mid_valid),
    .in_ready  (mid_ready),
    .in_data   (mid_data),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .out_data  (res)
  );

  // Spread the result onto the channel
  assign out_ch.epoch_seconds = res.epoch_seconds;
  assign out_ch.day_of_year   = res.day_of_year;
  assign out_ch.weekday       = res.weekday;
  assign out_ch.date_valid    = res.date_valid;

endmodule

`default_nettype wire
